// ----- rtl/llc_pkg.sv -----
// Shared codes, widths and constants of the latency ladder classifier.
`timescale 1ns / 1ps

package llc_pkg;

  // Request types carried by req_type.
  localparam logic [1:0] REQ_BEGIN    = 2'd0;
  localparam logic [1:0] REQ_LOAD     = 2'd1;
  localparam logic [1:0] REQ_COMMIT   = 2'd2;
  localparam logic [1:0] REQ_CLASSIFY = 2'd3;

  // Status codes of the status field.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BAD_KIND = 3'd2;
  localparam logic [2:0] ST_DUP_KIND = 3'd3;
  localparam logic [2:0] ST_FIRST_NZ = 3'd4;
  localparam logic [2:0] ST_NOT_INC  = 3'd5;
  localparam logic [2:0] ST_ZERO_THR = 3'd6;
  localparam logic [2:0] ST_TOO_MANY = 3'd7;

  // Error kinds; any kind other than success leaves an operation unjudged.
  localparam logic [3:0] EK_SUCCESS     = 4'd0;
  localparam logic [3:0] EK_THROTTLING  = 4'd1;
  localparam logic [3:0] EK_CKPT_REJECT = 4'd2;

  // Field and datapath widths.
  localparam int DATA_W = 32;
  localparam int LAT_W  = 36;
  localparam int CMP_W  = 42;
  localparam int SLOT_W = 3 * DATA_W;

  // Milliseconds to microseconds.
  localparam logic [9:0] MS_TO_US = 10'd1000;

endpackage

// ----- rtl/llc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module llc_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/latency_ladder_classifier_top.sv -----
// Top level of the latency ladder classifier: sequencer, ladder table and bucket scan.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  req_type .. error_kind (one item per request)
// output    out        out_valid/out_stall  count_skipped .. table_active (one item each)
//
// Every input item yields one output item. Begin and commit go straight to the finish state;
// a load and a classify step through their sequencer states, a classify scanning the ladder
// of its media kind one RAM entry per cycle. in_stall is high while an item is at work.
// A finished item waits in its last state until the output register is free; a result
// in that register waits while out_stall is high, and the next item may be taken meanwhile.
// Synchronous reset clears ladder lengths, build status and active flag, not the RAM.

module latency_ladder_classifier_top #(
  parameter int MEDIA_KINDS = 16,
  parameter int MAX_BUCKETS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  media_kind,
  input  logic        first_of_ladder,
  input  logic [31:0] min_request_bytes,
  input  logic [31:0] read_limit_ms,
  input  logic [31:0] write_limit_ms,
  input  logic        is_write,
  input  logic [31:0] request_bytes,
  input  logic [35:0] latency_us,
  input  logic        has_error,
  input  logic        was_cancelled,
  input  logic [3:0]  error_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        count_skipped,
  output logic        count_total,
  output logic        count_good,
  output logic [2:0]  status,
  output logic        warning,
  output logic        table_active
);

  localparam int DEPTH = MEDIA_KINDS * MAX_BUCKETS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = (MEDIA_KINDS > 1) ? $clog2(MEDIA_KINDS) : 1;
  localparam int IW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int LW    = $clog2(MAX_BUCKETS + 1);

  localparam int DW = llc_pkg::DATA_W;
  localparam int CW = llc_pkg::CMP_W;
  localparam int SW = llc_pkg::SLOT_W;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LKIND  = 9'b000000010,
    S_LLEN   = 9'b000000100,
    S_LCMP   = 9'b000001000,
    S_CLEN   = 9'b000010000,
    S_SCAN   = 9'b000100000,
    S_MUL    = 9'b001000000,
    S_JUDGE  = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t state;

  // Item fields held for the duration of the work.
  logic [7:0]        q_kind;
  logic [DW-1:0]     q_min;
  logic [DW-1:0]     q_rd;
  logic [DW-1:0]     q_wr;
  logic              q_is_write;
  logic [DW-1:0]     q_req;
  logic [35:0]       q_lat;
  logic              q_err;
  logic              q_canc;
  logic [3:0]        q_ek;

  // Table state.
  logic [LW-1:0]     ladder_len [MEDIA_KINDS];
  logic [KW-1:0]     loading_kind;
  logic [DW-1:0]     run_rd_max;
  logic [DW-1:0]     run_wr_max;
  logic              build_failed;
  logic [2:0]        fail_code;
  logic              active_flag;
  logic              any_loaded;

  // Working registers of the current item.
  logic [LW-1:0]     len_q;
  logic [IW-1:0]     scan_idx;
  logic [DW-1:0]     thr_q;
  logic [CW-1:0]     prod_q;
  logic              r_skip;
  logic              r_total;
  logic              r_good;
  logic [2:0]        r_status;
  logic              r_warn;

  // Combinational helpers.
  logic              accept;
  logic              out_load;
  logic [KW-1:0]     len_sel;
  logic [LW-1:0]     len_rd;
  logic [KW-1:0]     cls_kind;
  logic              kind_bad_q;
  logic              kind_bad_in;
  logic              zero_thr;
  logic              scan_last;
  logic              cls_skip_code;
  logic [CW-1:0]     cmp_a;
  logic [CW-1:0]     cmp_b;
  logic              cmp_le;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [SW-1:0]     ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [SW-1:0]     ram_rdata;
  logic [DW-1:0]     rd_min;
  logic [DW-1:0]     rd_rlim;
  logic [DW-1:0]     rd_wlim;

  // Flat RAM slot of bucket i of media kind k.
  function automatic logic [AW-1:0] slot(input logic [KW-1:0] k, input logic [IW-1:0] i);
    slot = AW'(AW'(k) * AW'(MAX_BUCKETS)) + AW'(i);
  endfunction

  assign accept      = in_valid && (state == S_IDLE);
  assign in_stall    = (state != S_IDLE);
  assign out_load    = (state == S_FINISH) && (!out_valid || !out_stall);
  assign cls_kind    = q_kind[KW-1:0];
  assign kind_bad_q  = ({1'b0, q_kind} >= 9'(MEDIA_KINDS));
  assign kind_bad_in = ({1'b0, media_kind} >= 9'(MEDIA_KINDS));
  assign zero_thr    = (q_rd == '0) || (q_wr == '0);
  // The kind check and the classify lookup read the item's kind, the load steps the
  // kind being loaded.
  assign len_sel     = ((state == S_LKIND) || (state == S_CLEN)) ? cls_kind : loading_kind;
  assign len_rd      = ladder_len[len_sel];
  assign scan_last   = ((LW'(scan_idx) + LW'(1)) == len_q);
  assign cls_skip_code = (q_ek == llc_pkg::EK_THROTTLING) ||
                         (q_ek == llc_pkg::EK_CKPT_REJECT) || q_canc;

  assign rd_min  = ram_rdata[3*DW-1:2*DW];
  assign rd_rlim = ram_rdata[2*DW-1:DW];
  assign rd_wlim = ram_rdata[DW-1:0];

  // The one comparator shared by the increase check, the bucket scan and the judgment.
  assign cmp_le = (cmp_a <= cmp_b);

  // RAM port control and comparator operands per state.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = slot(loading_kind, IW'(len_rd - LW'(1)));
    ram_we    = 1'b0;
    ram_waddr = slot(loading_kind, IW'(len_q));
    ram_wdata = {q_min, q_rd, q_wr};
    cmp_a     = CW'(q_min);
    cmp_b     = CW'(rd_min);
    unique case (state)
      S_LLEN: begin
        if ((len_rd < LW'(MAX_BUCKETS)) && (len_rd != '0)) begin
          ram_re = 1'b1;
        end
        if ((len_rd == '0) && (q_min == '0) && !zero_thr) begin
          ram_we    = 1'b1;
          ram_waddr = slot(loading_kind, '0);
        end
      end
      S_LCMP: begin
        if (!cmp_le && !zero_thr) begin
          ram_we = 1'b1;
        end
      end
      S_CLEN: begin
        ram_raddr = slot(cls_kind, '0);
        if ((len_rd != '0) && !cls_skip_code && !q_err &&
            (q_ek == llc_pkg::EK_SUCCESS)) begin
          ram_re = 1'b1;
        end
      end
      S_SCAN: begin
        cmp_a     = CW'(rd_min);
        cmp_b     = CW'(q_req);
        ram_raddr = slot(cls_kind, scan_idx + IW'(1));
        ram_re    = !scan_last;
      end
      S_JUDGE: begin
        cmp_a = CW'(q_lat);
        cmp_b = prod_q;
      end
      S_IDLE, S_LKIND, S_MUL, S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer and table updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      loading_kind <= '0;
      run_rd_max   <= '0;
      run_wr_max   <= '0;
      build_failed <= 1'b0;
      fail_code    <= llc_pkg::ST_OK;
      active_flag  <= 1'b0;
      any_loaded   <= 1'b0;
      r_skip       <= 1'b0;
      r_total      <= 1'b0;
      r_good       <= 1'b0;
      r_status     <= llc_pkg::ST_OK;
      r_warn       <= 1'b0;
      for (int k = 0; k < MEDIA_KINDS; k++) begin
        ladder_len[k] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          // The result registers are clear here; they are cleared as each item leaves.
          if (accept) begin
            q_kind     <= media_kind;
            q_min      <= min_request_bytes;
            q_rd       <= read_limit_ms;
            q_wr       <= write_limit_ms;
            q_is_write <= is_write;
            q_req      <= request_bytes;
            q_lat      <= latency_us;
            q_err      <= has_error;
            q_canc     <= was_cancelled;
            q_ek       <= error_kind;
            unique case (req_type)
              llc_pkg::REQ_BEGIN: begin
                loading_kind <= '0;
                run_rd_max   <= '0;
                run_wr_max   <= '0;
                build_failed <= 1'b0;
                fail_code    <= llc_pkg::ST_OK;
                active_flag  <= 1'b0;
                any_loaded   <= 1'b0;
                for (int k = 0; k < MEDIA_KINDS; k++) begin
                  ladder_len[k] <= '0;
                end
                state <= S_FINISH;
              end
              llc_pkg::REQ_LOAD: begin
                if (active_flag) begin
                  state <= S_FINISH;
                end else if (build_failed) begin
                  r_status <= fail_code;
                  state    <= S_FINISH;
                end else if (first_of_ladder) begin
                  state <= S_LKIND;
                end else begin
                  state <= S_LLEN;
                end
              end
              llc_pkg::REQ_COMMIT: begin
                if (build_failed) begin
                  r_status    <= fail_code;
                  active_flag <= 1'b0;
                end else if (!any_loaded) begin
                  r_status    <= llc_pkg::ST_EMPTY;
                  active_flag <= 1'b0;
                end else begin
                  active_flag <= 1'b1;
                end
                state <= S_FINISH;
              end
              llc_pkg::REQ_CLASSIFY: begin
                if (!active_flag || kind_bad_in) begin
                  r_skip <= 1'b1;
                  state  <= S_FINISH;
                end else begin
                  state <= S_CLEN;
                end
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end

        S_LKIND: begin
          if (kind_bad_q) begin
            build_failed <= 1'b1;
            fail_code    <= llc_pkg::ST_BAD_KIND;
            r_status     <= llc_pkg::ST_BAD_KIND;
            state        <= S_FINISH;
          end else if (len_rd != '0) begin
            build_failed <= 1'b1;
            fail_code    <= llc_pkg::ST_DUP_KIND;
            r_status     <= llc_pkg::ST_DUP_KIND;
            state        <= S_FINISH;
          end else begin
            loading_kind <= cls_kind;
            state        <= S_LLEN;
          end
        end

        S_LLEN: begin
          len_q <= len_rd;
          if (len_rd >= LW'(MAX_BUCKETS)) begin
            build_failed <= 1'b1;
            fail_code    <= llc_pkg::ST_TOO_MANY;
            r_status     <= llc_pkg::ST_TOO_MANY;
            state        <= S_FINISH;
          end else if (len_rd == '0) begin
            if (q_min != '0) begin
              build_failed <= 1'b1;
              fail_code    <= llc_pkg::ST_FIRST_NZ;
              r_status     <= llc_pkg::ST_FIRST_NZ;
            end else if (zero_thr) begin
              build_failed <= 1'b1;
              fail_code    <= llc_pkg::ST_ZERO_THR;
              r_status     <= llc_pkg::ST_ZERO_THR;
            end else begin
              // First bucket of a ladder: the running maxima restart here.
              run_rd_max               <= q_rd;
              run_wr_max               <= q_wr;
              ladder_len[loading_kind] <= LW'(1);
              any_loaded               <= 1'b1;
            end
            state <= S_FINISH;
          end else begin
            state <= S_LCMP;
          end
        end

        S_LCMP: begin
          if (cmp_le) begin
            build_failed <= 1'b1;
            fail_code    <= llc_pkg::ST_NOT_INC;
            r_status     <= llc_pkg::ST_NOT_INC;
          end else if (zero_thr) begin
            build_failed <= 1'b1;
            fail_code    <= llc_pkg::ST_ZERO_THR;
            r_status     <= llc_pkg::ST_ZERO_THR;
          end else begin
            r_warn <= (q_rd < run_rd_max) || (q_wr < run_wr_max);
            if (q_rd > run_rd_max) begin
              run_rd_max <= q_rd;
            end
            if (q_wr > run_wr_max) begin
              run_wr_max <= q_wr;
            end
            ladder_len[loading_kind] <= len_q + LW'(1);
            any_loaded               <= 1'b1;
          end
          state <= S_FINISH;
        end

        S_CLEN: begin
          len_q    <= len_rd;
          scan_idx <= '0;
          if ((len_rd == '0) || cls_skip_code) begin
            r_skip <= 1'b1;
            state  <= S_FINISH;
          end else if (q_err || (q_ek != llc_pkg::EK_SUCCESS)) begin
            r_total <= 1'b1;
            state   <= S_FINISH;
          end else begin
            r_total <= 1'b1;
            state   <= S_SCAN;
          end
        end

        S_SCAN: begin
          // Minimums rise strictly, so the last bucket that fits is the one kept.
          if (cmp_le) begin
            thr_q <= q_is_write ? rd_wlim : rd_rlim;
          end
          scan_idx <= scan_idx + IW'(1);
          if (scan_last) begin
            state <= S_MUL;
          end
        end

        S_MUL: begin
          prod_q <= CW'(thr_q) * CW'(llc_pkg::MS_TO_US);
          state  <= S_JUDGE;
        end

        S_JUDGE: begin
          r_good <= cmp_le;
          state  <= S_FINISH;
        end

        S_FINISH: begin
          if (out_load) begin
            count_skipped <= r_skip;
            count_total   <= r_total;
            count_good    <= r_good;
            status        <= r_status;
            warning       <= r_warn;
            table_active  <= active_flag;
            r_skip        <= 1'b0;
            r_total       <= 1'b0;
            r_good        <= 1'b0;
            r_status      <= llc_pkg::ST_OK;
            r_warn        <= 1'b0;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Bucket store: minimum, read limit and write limit side by side in one word.
  llc_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- rtl/llc_checker.sv -----
// Port-level assertions of the latency ladder classifier and their bind.
`timescale 1ns / 1ps

module llc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       count_skipped,
  input logic       count_total,
  input logic       count_good,
  input logic [2:0] status,
  input logic       warning
);

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(count_good))
    else $error("output item changed while stalled");

  // One item at a time: right after an accept the block is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again without working on the item");

  // A good operation always counts toward the total and is never skipped.
  a_good_is_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && count_good |-> count_total && !count_skipped)
    else $error("good operation not counted in total");

  // Skipped and total exclude each other, and classify items carry no load status.
  a_classify_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (count_skipped || count_total) |->
      !(count_skipped && count_total) && (status == llc_pkg::ST_OK) && !warning)
    else $error("classify result mixes counters or carries a status");

  // A warning only comes with a bucket that passed its checks.
  a_warning_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && warning |-> (status == llc_pkg::ST_OK))
    else $error("warning raised on a failing bucket");

endmodule

bind latency_ladder_classifier_top llc_checker u_llc_checker (.*);
